[design/qpht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

   // fixed field widths
   localparam int KEY_BITS  = 31;
   localparam int DATA_BITS = 32;

   // opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // result status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

[design/quadratic_probe_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// req_      in   req_valid/req_ready    req_opcode, req_key, req_value
// rsp_      out  rsp_valid/rsp_ready    rsp_found, rsp_read_value, rsp_status
//
// Sequence: one transfer in, then per probe a RAM read (S_READ) followed by a check and
// optional write (S_CHECK); S_RESP then loads the result register once the output is free.
// Reset: the key RAM is then swept one slot a cycle over all 2^LOG2_CAPACITY slots, req_ready low.
// Stalls: one item at a time, req_ready high only while idle. A finished result waits in
// the output register while the next request is taken; a later one waits in the sequencer.

module quadratic_probe_hash_table #(
   parameter int LOG2_CAPACITY = 10,
   parameter int VALUE_BITS    = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [qpht_pkg::KEY_BITS-1:0] req_key,
   input  wire logic [qpht_pkg::DATA_BITS-1:0] req_value,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [qpht_pkg::DATA_BITS-1:0]     rsp_read_value,
   output logic                               rsp_status
);

   localparam int CAPACITY = 1 << LOG2_CAPACITY;
   localparam int TAG_BITS = qpht_pkg::KEY_BITS + 1;
   localparam logic [LOG2_CAPACITY-1:0] LOAD_LIMIT =
      LOG2_CAPACITY'(CAPACITY - CAPACITY / 4);
   localparam logic [LOG2_CAPACITY-1:0] LAST_SLOT = LOG2_CAPACITY'(CAPACITY - 1);

   // Slot RAMs. Tag word = {used, key}; the used bit is cleared by the
   // post-reset sweep. The value RAM word is only used on a key match.
   logic [TAG_BITS-1:0]   tag_mem [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];

   logic [TAG_BITS-1:0]   tag_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   qpht_pkg::state_type state_ff, state_in;

   logic                               op_ff, op_in;
   logic [qpht_pkg::KEY_BITS-1:0]      key_ff, key_in;
   logic [qpht_pkg::DATA_BITS-1:0]     value_ff, value_in;
   logic [LOG2_CAPACITY-1:0]           pos_ff, pos_in;     // probe slot / sweep address
   logic [LOG2_CAPACITY-1:0]           cnt_ff, cnt_in;     // probe index
   logic [LOG2_CAPACITY-1:0]           count_ff, count_in; // stored keys

   logic                               res_found_ff, res_found_in;
   logic [qpht_pkg::DATA_BITS-1:0]     res_value_ff, res_value_in;
   logic                               res_status_ff, res_status_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [qpht_pkg::DATA_BITS-1:0]     rsp_read_value_ff, rsp_read_value_in;
   logic                               rsp_status_ff, rsp_status_in;

   logic                  tag_we;
   logic [TAG_BITS-1:0]   tag_wdata;
   logic                  val_we;
   logic [VALUE_BITS-1:0] val_wdata;

   logic                          slot_used;
   logic                          key_match;
   logic [63:0]                   rd_wide;
   logic [63:0]                   wr_wide;

   assign slot_used = tag_rd_ff[TAG_BITS-1];
   assign key_match = slot_used && (tag_rd_ff[qpht_pkg::KEY_BITS-1:0] == key_ff);

   // value width adaption: store low VALUE_BITS, read back zero-extended
   assign rd_wide   = 64'(val_rd_ff);
   assign wr_wide   = {32'd0, value_ff};
   assign val_wdata = wr_wide[VALUE_BITS-1:0];

   assign req_ready      = (state_ff == qpht_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   // RAMs: one write port at pos_ff, registered read at pos_ff
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[pos_ff] <= tag_wdata;
      end
      if (val_we) begin
         val_mem[pos_ff] <= val_wdata;
      end
      if (state_ff == qpht_pkg::S_READ) begin
         tag_rd_ff <= tag_mem[pos_ff];
         val_rd_ff <= val_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qpht_pkg::S_CLEAR;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      key_ff            <= key_in;
      value_ff          <= value_in;
      cnt_ff            <= cnt_in;
      res_found_ff      <= res_found_in;
      res_value_ff      <= res_value_in;
      res_status_ff     <= res_status_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      value_in          = value_ff;
      pos_in            = pos_ff;
      cnt_in            = cnt_ff;
      count_in          = count_ff;
      res_found_in      = res_found_ff;
      res_value_in      = res_value_ff;
      res_status_in     = res_status_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_found_in      = rsp_found_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      tag_we            = 1'b0;
      tag_wdata         = {1'b1, key_ff};
      val_we            = 1'b0;

      case (state_ff)
         qpht_pkg::S_CLEAR: begin
            // mark every slot empty
            tag_we    = 1'b1;
            tag_wdata = '0;
            pos_in    = pos_ff + 1'b1;
            if (pos_ff == LAST_SLOT) begin
               state_in = qpht_pkg::S_IDLE;
            end
         end

         qpht_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               key_in   = req_key;
               value_in = req_value;
               pos_in   = req_key[LOG2_CAPACITY-1:0];
               cnt_in   = '0;
               state_in = qpht_pkg::S_READ;
            end
         end

         qpht_pkg::S_READ: begin
            state_in = qpht_pkg::S_CHECK;
         end

         qpht_pkg::S_CHECK: begin
            res_found_in  = 1'b0;
            res_value_in  = '0;
            res_status_in = qpht_pkg::STATUS_DONE;
            if (!slot_used || key_match) begin
               // probe run ends: empty slot or key hit
               state_in = qpht_pkg::S_RESP;
               if (op_ff == qpht_pkg::OP_GET) begin
                  res_found_in = key_match;
                  if (key_match) begin
                     res_value_in = rd_wide[qpht_pkg::DATA_BITS-1:0];
                  end
               end else if (key_match) begin
                  // overwrite, count unchanged
                  res_found_in = 1'b1;
                  val_we       = 1'b1;
               end else if (count_ff < LOAD_LIMIT) begin
                  tag_we   = 1'b1;
                  val_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  res_status_in = qpht_pkg::STATUS_FULL;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               // whole probe path seen without a stop
               state_in = qpht_pkg::S_RESP;
               if (op_ff == qpht_pkg::OP_PUT) begin
                  res_status_in = qpht_pkg::STATUS_FULL;
               end
            end else begin
               // triangular step: slot += index + 1
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = pos_ff + cnt_ff + 1'b1;
               state_in = qpht_pkg::S_READ;
            end
         end

         qpht_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_found_in      = res_found_ff;
               rsp_read_value_in = res_value_ff;
               rsp_status_in     = res_status_ff;
               state_in          = qpht_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = qpht_pkg::S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // an accepted request always starts with a RAM read
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == qpht_pkg::S_READ)
      else $error("accepted request did not start a probe");

   // key count never passes the load limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LOAD_LIMIT)
      else $error("key count above load limit");

   // a new result only comes out of the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == qpht_pkg::S_RESP))
      else $error("result raised outside response state");

   // a rejected put reports neither a hit nor a value
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == qpht_pkg::STATUS_FULL
      |-> !rsp_found_ff && rsp_read_value_ff == '0)
      else $error("full status with found or value set");
`endif

endmodule

`default_nettype wire
